/* hdl/trend_buffer_point_decimator_unit_macros.svh */
// ----------------------------------------------------------------------------
// trend buffer point decimator - assertion macros
// shared assertion forms, sampled on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef TREND_BUFFER_POINT_DECIMATOR_UNIT_MACROS_SVH
`define TREND_BUFFER_POINT_DECIMATOR_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define TBPD_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TBPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tbpd_pkg.sv */
// ----------------------------------------------------------------------------
// tbpd_pkg
// types and constants shared by the trend buffer point decimator modules
// ----------------------------------------------------------------------------
package tbpd_pkg;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [15:0] WEIGHT_RESET = 16'd6554;

  localparam int DIV_STEPS = 32;
  localparam int IN_BYTES  = 9;
  localparam int OUT_BYTES = 10;

  // controller to datapath
  typedef struct packed {
    logic cap_in;
    logic wr_app;
    logic ptr_clr;
    logic ptr_inc;
    logic ptr_best;
    logic win_shift;
    logic prep;
    logic mul;
    logic div_start;
    logic cap_div;
    logic interp;
    logic err;
    logic sig;
    logic cmp;
    logic si_inc;
    logic shift_wr;
    logic cnt_dec;
    logic rem_set;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic newer;
    logic over;
    logic scan_last;
    logic shift_last;
    logic div_done;
  } sta_t;

endpackage

/* hdl/tbpd_div.sv */
// ----------------------------------------------------------------------------
// tbpd_div
// restoring divider, one quotient bit per cycle, 64 by 33 bit with 32 bit
// quotient; the upper half of the dividend must be below the divisor
// ----------------------------------------------------------------------------
module tbpd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic        busy;
  logic [4:0]  step;
  logic [33:0] rem;
  logic [31:0] nlo;
  logic [32:0] den_r;
  logic [33:0] trial;
  logic        ge;

  assign trial = {rem[32:0], nlo[31]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'(tbpd_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {2'b00, num[63:32]};
      nlo   <= num[31:0];
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? (trial - {1'b0, den_r}) : trial;
      nlo <= {nlo[30:0], 1'b0};
      quo <= {quo[30:0], ge};
    end
  end

endmodule

/* hdl/tbpd_dp.sv */
// ----------------------------------------------------------------------------
// tbpd_dp
// point store, neighbour window, significance arithmetic, best search
// registers and result word
// ----------------------------------------------------------------------------
`include "trend_buffer_point_decimator_unit_macros.svh"

module tbpd_dp #(
  parameter int MAX_POINTS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tbpd_pkg::cmd_t                     cmd,
  output tbpd_pkg::sta_t                     st,
  input  logic                               cfg_we,
  input  logic [15:0]                        cfg_wdata,
  input  logic [0:0]                         in_user,
  input  logic [tbpd_pkg::IN_BYTES*8-1:0]    in_data,
  output logic [tbpd_pkg::OUT_BYTES*8-1:0]   out_data
);

  localparam int DEPTH = MAX_POINTS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [63:0]        mem [DEPTH];
  logic [63:0]        rdata;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [63:0]        wdata;
  logic               we;

  logic [15:0]        weight;
  logic [CW-1:0]      count;
  logic [31:0]        last_tick;
  logic               is_read;
  logic [31:0]        tick_l;
  logic [31:0]        value_l;
  logic [5:0]         ridx;
  logic               acc_f;
  logic               rem_f;

  logic [AW-1:0]      ptr;
  logic [AW-1:0]      si;
  logic [AW-1:0]      best;
  logic [35:0]        best_sig;
  logic               take;
  logic [AW-1:0]      best_pick;

  logic [63:0]        wp;
  logic [63:0]        wc;
  logic [63:0]        wn;

  logic [31:0]        range_r;
  logic [31:0]        offset_r;
  logic [31:0]        mag_r;
  logic               neg_r;
  logic [63:0]        prod;
  logic [31:0]        q_r;
  logic [15:0]        wq_r;
  logic signed [33:0] interp_r;
  logic signed [34:0] err_r;
  logic [35:0]        sig_r;

  logic               q_done;
  logic               w_done;
  logic [31:0]        q_quo;
  logic [31:0]        w_quo;

  logic signed [32:0] diff;
  logic [34:0]        err_abs;
  logic               rd_ok;
  logic [31:0]        rd_tick;
  logic [31:0]        rd_value;

  // point store
  assign raddr = is_read ? AW'(ridx) : ptr;
  assign we    = cmd.wr_app | cmd.shift_wr;
  assign waddr = cmd.wr_app ? AW'(count) : (ptr - AW'(1));
  assign wdata = cmd.wr_app ? {value_l, tick_l} : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= tbpd_pkg::WEIGHT_RESET;
      count  <= '0;
      acc_f  <= 1'b0;
      rem_f  <= 1'b0;
    end else begin
      if (cfg_we) begin
        weight <= cfg_wdata;
      end
      if (cmd.cap_in) begin
        acc_f <= 1'b0;
        rem_f <= 1'b0;
      end
      if (cmd.wr_app) begin
        count <= count + CW'(1);
        acc_f <= 1'b1;
      end
      if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.rem_set) begin
        rem_f <= 1'b1;
      end
    end
  end

  // winner of the compare, including the point being compared now
  assign take      = (si == AW'(1)) || (sig_r < best_sig);
  assign best_pick = take ? si : best;

  // item, window and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      is_read <= in_user[0] == tbpd_pkg::CMD_READ;
      tick_l  <= in_data[31:0];
      value_l <= in_data[63:32];
      ridx    <= in_data[69:64];
    end
    if (cmd.wr_app) begin
      last_tick <= tick_l;
    end
    if (cmd.ptr_clr) begin
      ptr <= '0;
      si  <= AW'(1);
    end else if (cmd.ptr_best) begin
      ptr <= best_pick + AW'(1);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + AW'(1);
    end
    if (cmd.si_inc) begin
      si <= si + AW'(1);
    end
    if (cmd.win_shift) begin
      wp <= wc;
      wc <= wn;
      wn <= rdata;
    end
    if (cmd.prep) begin
      range_r  <= wn[31:0] - wp[31:0];
      offset_r <= wc[31:0] - wp[31:0];
      neg_r    <= diff[32];
      mag_r    <= diff[32] ? 32'(-diff) : diff[31:0];
    end
    if (cmd.mul) begin
      prod <= 64'(mag_r) * 64'(offset_r);
    end
    if (cmd.cap_div) begin
      q_r  <= (range_r == 32'd0) ? 32'd0 : q_quo;
      wq_r <= w_quo[15:0];
    end
    if (cmd.interp) begin
      interp_r <= neg_r ? (34'(signed'(wp[63:32])) - signed'({2'b00, q_r}))
                        : (34'(signed'(wp[63:32])) + signed'({2'b00, q_r}));
    end
    if (cmd.err) begin
      err_r <= 35'(signed'(wc[63:32])) - 35'(interp_r);
    end
    if (cmd.sig) begin
      sig_r <= {1'b0, err_abs} + 36'(wq_r);
    end
    if (cmd.cmp) begin
      if (take) begin
        best_sig <= sig_r;
        best     <= si;
      end
    end
  end

  assign diff    = 33'(signed'(wn[63:32])) - 33'(signed'(wp[63:32]));
  assign err_abs = err_r[34] ? 35'(-err_r) : 35'(err_r);

  // both quotients run side by side
  tbpd_div u_div_q (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (prod),
    .den   ({1'b0, range_r}),
    .done  (q_done),
    .quo   (q_quo)
  );

  tbpd_div u_div_w (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({48'd0, weight}),
    .den   ({1'b0, range_r} + 33'd1),
    .done  (w_done),
    .quo   (w_quo)
  );

  // status
  assign st.is_read    = is_read;
  assign st.newer      = (count == '0) || (tick_l > last_tick);
  assign st.over       = count > CW'(MAX_POINTS);
  assign st.scan_last  = CW'(si) == (count - CW'(2));
  assign st.shift_last = CW'(ptr) == (count - CW'(1));
  assign st.div_done   = q_done;

  // result word
  assign rd_ok    = is_read && ((CW + 7)'(ridx) < (CW + 7)'(count));
  assign rd_tick  = rd_ok ? rdata[31:0] : 32'd0;
  assign rd_value = rd_ok ? rdata[63:32] : 32'd0;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {rd_value, rd_tick, rd_ok, 7'(count),
                   rem_f ? 6'(best) : 6'd0, rem_f, acc_f};
    end
  end

  `TBPD_ASSERT_HOLDS(a_count_bound, 1'b1, count <= CW'(DEPTH), "point count beyond store depth")
  `TBPD_ASSERT_NEXT(a_append_grows, cmd.wr_app, count == $past(count) + CW'(1), "append lost")
  `TBPD_ASSERT_HOLDS(a_dec_when_full, cmd.cnt_dec, count == CW'(DEPTH), "erase without overflow")
  `TBPD_ASSERT_HOLDS(a_div_lockstep, q_done, w_done, "dividers out of step")

endmodule

/* hdl/tbpd_ctrl.sv */
// ----------------------------------------------------------------------------
// tbpd_ctrl
// sequencer for append, neighbour scan, shift down, read and result handoff
// ----------------------------------------------------------------------------
module tbpd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  output logic           m_valid,
  input  logic           m_ready,
  input  tbpd_pkg::sta_t st,
  output tbpd_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_TEST,
    S_L0,
    S_L1,
    S_L2,
    S_L3,
    S_PREP,
    S_MUL,
    S_DIVS,
    S_DIVW,
    S_INTERP,
    S_ERR,
    S_SIG,
    S_CMP,
    S_ADV,
    S_ADV2,
    S_SH_RD,
    S_SH_WR,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   load;

  assign s_ready = state == S_IDLE;
  assign load    = (state == S_OUT) && (!m_valid || m_ready);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.cap_in = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_read) begin
          state_next = S_OUT;
        end else if (st.newer) begin
          cmd.wr_app = 1'b1;
          state_next = S_TEST;
        end else begin
          state_next = S_OUT;
        end
      end
      S_TEST: begin
        if (st.over) begin
          cmd.ptr_clr = 1'b1;
          cmd.rem_set = 1'b1;
          state_next  = S_L0;
        end else begin
          state_next = S_OUT;
        end
      end
      S_L0: begin
        cmd.ptr_inc = 1'b1;
        state_next  = S_L1;
      end
      S_L1: begin
        cmd.ptr_inc   = 1'b1;
        cmd.win_shift = 1'b1;
        state_next    = S_L2;
      end
      S_L2: begin
        cmd.ptr_inc   = 1'b1;
        cmd.win_shift = 1'b1;
        state_next    = S_L3;
      end
      S_L3: begin
        cmd.win_shift = 1'b1;
        state_next    = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (st.div_done) begin
          cmd.cap_div = 1'b1;
          state_next  = S_INTERP;
        end
      end
      S_INTERP: begin
        cmd.interp = 1'b1;
        state_next = S_ERR;
      end
      S_ERR: begin
        cmd.err    = 1'b1;
        state_next = S_SIG;
      end
      S_SIG: begin
        cmd.sig    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (st.scan_last) begin
          cmd.ptr_best = 1'b1;
          state_next   = S_SH_RD;
        end else begin
          cmd.si_inc = 1'b1;
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        cmd.ptr_inc = 1'b1;
        state_next  = S_ADV2;
      end
      S_ADV2: begin
        cmd.win_shift = 1'b1;
        state_next    = S_PREP;
      end
      S_SH_RD: begin
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        if (st.shift_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_OUT;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_SH_RD;
        end
      end
      S_OUT: begin
        if (load) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/trend_buffer_point_decimator_unit.sv */
// ----------------------------------------------------------------------------
// trend_buffer_point_decimator_unit
// ordered (tick, value) point buffer thinned by dropping the least
// significant interior point when full; reads return one stored point
//
//   channel  | dir | handshake                     | contents
//   s_axis   | in  | s_axis_tvalid / s_axis_tready | command word
//   m_axis   | out | m_axis_tvalid / m_axis_tready | one result word per command
//   cfg      | in  | cfg_we                        | density weight
//
// read or rejected append: decode, then result; append without overflow:
//   decode, test, then result; append with overflow: a scan of each interior
//   point through the two 32-step serial dividers, then a store shift down
// one word at a time; a new word is taken once the result sits in the output
//   register; the sequencer waits to load while a held word sees m_axis_tready low
// rst is synchronous; point count and density weight reset, store is unset
// ----------------------------------------------------------------------------
module trend_buffer_point_decimator_unit #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_tick[31:0], sample_value[63:32], read_index[69:64], zero fill
  input  logic [71:0] s_axis_tdata,
  // command[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // accepted[0], removed_valid[1], removed_index[7:2], point_count[14:8],
  // read_valid[15], read_tick[47:16], read_value[79:48]
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  tbpd_pkg::cmd_t cmd;
  tbpd_pkg::sta_t st;

  tbpd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .st      (st),
    .cmd     (cmd)
  );

  tbpd_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_user   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata)
  );

endmodule
